// File: design/bmmd_pkg.sv
`default_nettype none

package bmmd_pkg;

	typedef enum logic [3:0] {
		REGION_FIXED_ROM  = 4'd0,
		REGION_BANKED_ROM = 4'd1,
		REGION_VRAM       = 4'd2,
		REGION_EXT_RAM    = 4'd3,
		REGION_WORK_RAM   = 4'd4,
		REGION_OAM        = 4'd5,
		REGION_UNUSED     = 4'd6,
		REGION_HIGH_RAM   = 4'd7,
		REGION_IRQ_ENABLE = 4'd8,
		REGION_IO         = 4'd9,
		REGION_BANK_CTRL  = 4'd10
	} region_t;

	// Bank controller register windows, selected by address[14:13] below 0x8000.
	typedef enum logic [1:0] {
		CTRL_RAM_ENABLE = 2'd0,
		CTRL_ROM_LOWER  = 2'd1,
		CTRL_ROM_UPPER  = 2'd2,
		CTRL_MODE       = 2'd3
	} ctrl_sel_t;

	localparam int unsigned ADDR_W   = 16;
	localparam int unsigned DATA_W   = 8;
	localparam int unsigned OFFSET_W = 21;
	localparam int unsigned ROM_BANK_W = 7;
	localparam int unsigned RAM_BANK_W = 2;

	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
	localparam logic [7:0] OAM_LAST       = 8'h9F;
	localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 7'd1;

	// Banks whose lower five bits are zero cannot be mapped; step to the next one.
	function automatic logic [ROM_BANK_W-1:0] bump_bank(input logic [ROM_BANK_W-1:0] bank);
		logic [ROM_BANK_W-1:0] res;
		res = bank;
		if (bank[4:0] == 5'd0) begin
			res = bank + 7'd1;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: design/banked_memory_map_decoder.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        sink       in_valid / in_ready     op, address, data
// out       source     out_valid / out_ready   region, offset, ext_ram_en, current_rom_bank
// cfg       sink       cfg_valid / cfg_ready   cfg_data (banking_enabled)
//
// One access per cycle unless the result stalls; stage one feeds the result register.
// Stage one registers the access, the decode and bank update sit between stage one and
// the result register. The bank registers update as an access leaves stage one.
// arst_n clears both stages and sets bank 1, RAM bank 0, RAM disabled, ROM banking mode.
// A stalled result holds stage two and a full stage one; an empty stage one still takes
// one access. The configuration port is always ready.
module banked_memory_map_decoder (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             op,
	input  wire logic [bmmd_pkg::ADDR_W-1:0]      address,
	input  wire logic [bmmd_pkg::DATA_W-1:0]      data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [3:0]                            region,
	output logic [bmmd_pkg::OFFSET_W-1:0]         offset,
	output logic                                  ext_ram_en,
	output logic [bmmd_pkg::ROM_BANK_W-1:0]       current_rom_bank,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic                             cfg_data
);
	import bmmd_pkg::*;

	logic                    valid_s1;
	logic                    op_s1;
	logic [ADDR_W-1:0]       addr_s1;
	logic [DATA_W-1:0]       data_s1;

	logic                    valid_s2;
	region_t                 region_s2;
	logic [OFFSET_W-1:0]     offset_s2;
	logic                    ram_en_s2;
	logic [ROM_BANK_W-1:0]   rom_bank_s2;

	logic                    banking_en_q;
	logic [ROM_BANK_W-1:0]   rom_bank_q;
	logic [RAM_BANK_W-1:0]   ram_bank_q;
	logic                    ram_en_q;
	logic                    mode_q;

	logic                    adv;
	logic                    bank_wr;
	logic [ROM_BANK_W-1:0]   rom_bank_d;
	logic [RAM_BANK_W-1:0]   ram_bank_d;
	logic                    ram_en_d;
	logic                    mode_d;
	region_t                 region_d;
	logic [OFFSET_W-1:0]     offset_d;

	assign adv       = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			banking_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			banking_en_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			addr_s1 <= address;
			data_s1 <= data;
		end
	end

	// Bank controller update for the access in stage one.
	assign bank_wr = valid_s1 && op_s1 && !addr_s1[15] && banking_en_q;

	always_comb begin
		rom_bank_d = rom_bank_q;
		ram_bank_d = ram_bank_q;
		ram_en_d   = ram_en_q;
		mode_d     = mode_q;
		if (bank_wr) begin
			case (ctrl_sel_t'(addr_s1[14:13]))
				CTRL_RAM_ENABLE: ram_en_d = (data_s1[3:0] == RAM_ENABLE_KEY);
				CTRL_ROM_LOWER:  rom_bank_d = bump_bank({rom_bank_q[6:5], data_s1[4:0]});
				CTRL_ROM_UPPER: begin
					if (!mode_q) begin
						rom_bank_d = bump_bank({data_s1[1:0], rom_bank_q[4:0]});
					end else begin
						ram_bank_d = data_s1[1:0];
					end
				end
				CTRL_MODE:       mode_d = (data_s1 != '0);
				default:         mode_d = mode_q;
			endcase
		end
	end

	always_comb begin
		region_d = REGION_IO;
		offset_d = {{(OFFSET_W-8){1'b0}}, addr_s1[7:0]};
		if (!addr_s1[15]) begin
			if (op_s1) begin
				region_d = REGION_BANK_CTRL;
				offset_d = {{(OFFSET_W-ADDR_W){1'b0}}, addr_s1};
			end else if (!addr_s1[14]) begin
				region_d = REGION_FIXED_ROM;
				offset_d = {{(OFFSET_W-ADDR_W){1'b0}}, addr_s1};
			end else begin
				region_d = REGION_BANKED_ROM;
				offset_d = {rom_bank_q, addr_s1[13:0]};
			end
		end else if (addr_s1[15:13] == 3'b100) begin
			region_d = REGION_VRAM;
			offset_d = {{(OFFSET_W-13){1'b0}}, addr_s1[12:0]};
		end else if (addr_s1[15:13] == 3'b101) begin
			region_d = REGION_EXT_RAM;
			offset_d = {{(OFFSET_W-15){1'b0}}, ram_bank_q, addr_s1[12:0]};
		end else if (addr_s1[15:9] != 7'h7F) begin
			region_d = REGION_WORK_RAM;
			offset_d = {{(OFFSET_W-13){1'b0}}, addr_s1[12:0]};
		end else if (!addr_s1[8]) begin
			if (addr_s1[7:0] <= OAM_LAST) begin
				region_d = REGION_OAM;
			end else begin
				region_d = REGION_UNUSED;
				offset_d = '0;
			end
		end else if (addr_s1[7:0] == 8'hFF) begin
			region_d = REGION_IRQ_ENABLE;
			offset_d = '0;
		end else if (addr_s1[7]) begin
			region_d = REGION_HIGH_RAM;
			offset_d = {{(OFFSET_W-7){1'b0}}, addr_s1[6:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_q <= ROM_BANK_RESET;
			ram_bank_q <= '0;
			ram_en_q   <= 1'b0;
			mode_q     <= 1'b0;
		end else if (valid_s1 && adv) begin
			rom_bank_q <= rom_bank_d;
			ram_bank_q <= ram_bank_d;
			ram_en_q   <= ram_en_d;
			mode_q     <= mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			region_s2   <= region_d;
			offset_s2   <= offset_d;
			ram_en_s2   <= ram_en_d;
			rom_bank_s2 <= rom_bank_d;
		end
	end

	assign out_valid        = valid_s2;
	assign region           = region_s2;
	assign offset           = offset_s2;
	assign ext_ram_en       = ram_en_s2;
	assign current_rom_bank = rom_bank_s2;

`ifndef SYNTHESIS
	a_bank_never_zero_low: assert property (@(posedge clk) disable iff (!arst_n)
		rom_bank_q[4:0] != 5'd0)
		else $error("ROM bank has zero lower bits");

	a_disabled_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv && !banking_en_q |=> $stable(rom_bank_q) && $stable(ram_bank_q)
			&& $stable(ram_en_q) && $stable(mode_q))
		else $error("bank state changed with banking disabled");

	a_ram_bank_needs_mode: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(ram_bank_q) |-> $past(mode_q))
		else $error("RAM bank changed in ROM banking mode");

	a_banked_offset_bank: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && region_s2 == REGION_BANKED_ROM |-> offset_s2[20:14] == rom_bank_s2)
		else $error("banked ROM offset does not match reported bank");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(addr_s1) && $stable(op_s1))
		else $error("stage one lost its access during a stall");
`endif

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import bmmd_pkg::*;

	localparam logic OP_READ      = 1'b0;
	localparam logic OP_WRITE     = 1'b1;
	localparam int   DRAIN_CYCLES = 8;
	localparam int   DRAIN_LIMIT  = 5000;

	typedef struct packed {
		region_t                region;
		logic [OFFSET_W-1:0]    offset;
		logic                   ram_en;
		logic [ROM_BANK_W-1:0]  rom_page;
	} access_result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic                   op        = OP_READ;
	logic [ADDR_W-1:0]      address   = '0;
	logic [DATA_W-1:0]      data      = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [3:0]             region;
	logic [OFFSET_W-1:0]    offset;
	logic                   ext_ram_en;
	logic [ROM_BANK_W-1:0]  current_rom_bank;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_data  = 1'b0;

	// Shadow copy of the bank controller and its configuration.
	logic                   mbc_present = 1'b0;
	logic [ROM_BANK_W-1:0]  sh_rom_page = ROM_BANK_RESET;
	logic [RAM_BANK_W-1:0]  sh_ram_page = '0;
	logic                   ram_en      = 1'b0;
	logic                   ram_mode    = 1'b0;

	access_result_t         pending_q[$];
	access_result_t         want;
	int                     errors        = 0;
	int                     checked       = 0;
	int                     bank_updates  = 0;
	int                     region_hits[11];
	int                     burst_left    = 0;
	int                     gap_max       = 4;
	logic                   rx_no_stall   = 1'b0;
	int                     rx_mode       = 0;
	int                     rx_count      = 0;

	banked_memory_map_decoder u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.op               (op),
		.address          (address),
		.data             (data),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.region           (region),
		.offset           (offset),
		.ext_ram_en       (ext_ram_en),
		.current_rom_bank (current_rom_bank),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [ROM_BANK_W-1:0] skip_zero_bank(input logic [ROM_BANK_W-1:0] b);
		return (b[4:0] == 5'd0) ? b + 7'd1 : b;
	endfunction

	// Advances the shadow controller by one access and returns what the block should report.
	function automatic access_result_t decode_access(input logic wr, input logic [15:0] a,
			input logic [7:0] d);
		access_result_t r;
		r.offset = '0;
		if (!a[15]) begin
			if (wr == OP_WRITE) begin
				if (mbc_present) begin
					bank_updates++;
					case (ctrl_sel_t'(a[14:13]))
						CTRL_RAM_ENABLE: ram_en = (d[3:0] == RAM_ENABLE_KEY);
						CTRL_ROM_LOWER:  sh_rom_page = skip_zero_bank({sh_rom_page[6:5], d[4:0]});
						CTRL_ROM_UPPER: begin
							if (!ram_mode)
								sh_rom_page = skip_zero_bank({d[1:0], sh_rom_page[4:0]});
							else
								sh_ram_page = d[1:0];
						end
						default:         ram_mode = (d != 8'd0);
					endcase
				end
				r.region = REGION_BANK_CTRL;
				r.offset = OFFSET_W'(a);
			end else if (!a[14]) begin
				r.region = REGION_FIXED_ROM;
				r.offset = OFFSET_W'(a);
			end else begin
				r.region = REGION_BANKED_ROM;
				r.offset = {sh_rom_page, a[13:0]};
			end
		end else if (a < 16'hA000) begin
			r.region = REGION_VRAM;
			r.offset = OFFSET_W'(a[12:0]);
		end else if (a < 16'hC000) begin
			r.region = REGION_EXT_RAM;
			r.offset = OFFSET_W'({sh_ram_page, a[12:0]});
		end else if (a < 16'hFE00) begin
			r.region = REGION_WORK_RAM;
			r.offset = OFFSET_W'(a[12:0]);
		end else if (a < 16'hFF00) begin
			if (a[7:0] <= OAM_LAST) begin
				r.region = REGION_OAM;
				r.offset = OFFSET_W'(a[7:0]);
			end else begin
				r.region = REGION_UNUSED;
			end
		end else if (a == 16'hFFFF) begin
			r.region = REGION_IRQ_ENABLE;
		end else if (a > 16'hFF7F) begin
			r.region = REGION_HIGH_RAM;
			r.offset = OFFSET_W'(a[6:0]);
		end else begin
			r.region = REGION_IO;
			r.offset = OFFSET_W'(a[7:0]);
		end
		r.ram_en   = ram_en;
		r.rom_page = sh_rom_page;
		return r;
	endfunction

	// Sends one access beat; the sender runs in bursts with random gaps between them.
	task automatic send_access(input logic wr, input logic [15:0] a, input logic [7:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		op       <= wr;
		address  <= a;
		data     <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_q.push_back(decode_access(wr, a, d));
	endtask

	task automatic drain_pipeline();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_banking(input logic en);
		drain_pipeline();
		cfg_valid <= 1'b1;
		cfg_data  <= en;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		mbc_present = en;
	endtask

	// Mostly controller writes and reads of the banked windows, with plain traffic mixed in.
	task automatic send_random_access();
		logic        wr;
		logic [15:0] a;
		logic [7:0]  d;
		wr = 1'($urandom);
		a  = 16'($urandom);
		d  = 8'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				wr = OP_WRITE;
				a[15] = 1'b0;
				if ($urandom_range(0, 3) == 0)
					d = {4'($urandom), RAM_ENABLE_KEY};
				else if ($urandom_range(0, 5) == 0)
					d = 8'd0;
			end
			4, 5: begin
				wr = OP_READ;
				a[15:14] = 2'b01;
			end
			6:       a[15:13] = 3'b101;
			7:       a[15:9] = 7'h7F;
			default: ;
		endcase
		send_access(wr, a, d);
	endtask

	task automatic test_fixed_map();
		set_banking(1'b0);
		send_access(OP_READ,  16'h0000, 8'hFF);
		send_access(OP_READ,  16'h3FFF, 8'h00);
		send_access(OP_READ,  16'h4000, 8'hFF);
		send_access(OP_READ,  16'h7FFF, 8'h00);
		send_access(OP_READ,  16'h9FFF, 8'hFF);
		send_access(OP_READ,  16'hA000, 8'h00);
		send_access(OP_WRITE, 16'hBFFF, 8'hFF);
		send_access(OP_READ,  16'hC000, 8'h00);
		send_access(OP_WRITE, 16'hFDFF, 8'hFF);
		send_access(OP_READ,  16'hFE9F, 8'h00);
		send_access(OP_READ,  16'hFEA0, 8'hFF);
		send_access(OP_READ,  16'hFF7F, 8'h00);
		send_access(OP_READ,  16'hFF80, 8'hFF);
		send_access(OP_WRITE, 16'hFFFF, 8'hFF);
		// Without the controller these must leave the bank state alone.
		send_access(OP_WRITE, 16'h2000, 8'h05);
		send_access(OP_WRITE, 16'h0000, 8'h0A);
	endtask

	task automatic test_bank_controller();
		set_banking(1'b1);
		send_access(OP_WRITE, 16'h1FFF, 8'h1A);
		send_access(OP_WRITE, 16'h2000, 8'h00);
		send_access(OP_WRITE, 16'h3FFF, 8'h1F);
		send_access(OP_WRITE, 16'h4000, 8'h03);
		// A zero lower bank keeps the upper bits, then steps past the zero bank.
		send_access(OP_WRITE, 16'h2000, 8'hE0);
		send_access(OP_READ,  16'h7FFF, 8'h00);
		send_access(OP_WRITE, 16'h4000, 8'hFC);
		send_access(OP_WRITE, 16'h6000, 8'h80);
		send_access(OP_WRITE, 16'h5FFF, 8'h03);
		send_access(OP_READ,  16'hBFFF, 8'h00);
		send_access(OP_WRITE, 16'h7FFF, 8'h00);
		send_access(OP_WRITE, 16'h4000, 8'h02);
		send_access(OP_READ,  16'h4000, 8'h00);
		send_access(OP_WRITE, 16'h0000, 8'hF5);
	endtask

	task automatic test_random_traffic(input int n);
		repeat (n) send_random_access();
	endtask

	task automatic test_back_to_back(input int n);
		gap_max = 0;
		rx_no_stall = 1'b1;
		test_random_traffic(n);
		drain_pipeline();
		gap_max = 4;
		rx_no_stall = 1'b0;
	endtask

	// The receiver picks a stall pattern of its own and holds it for a random stretch.
	always @(posedge clk) begin
		if (rx_count == 0) begin
			rx_mode  = $urandom_range(0, 3);
			rx_count = $urandom_range(20, 80);
		end else begin
			rx_count--;
		end
		if (rx_no_stall)
			out_ready <= 1'b1;
		else
			case (rx_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 3) != 0);
				2:       out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ~out_ready;
			endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$error("result beat with nothing pending: region=%0d offset=0x%0h",
					region, offset);
				errors++;
			end else begin
				want = pending_q.pop_front();
				checked++;
				region_hits[int'(want.region)]++;
				if (region !== want.region) begin
					$error("region: expected %0d, got %0d", want.region, region);
					errors++;
				end
				if (offset !== want.offset) begin
					$error("offset: expected 0x%0h, got 0x%0h", want.offset, offset);
					errors++;
				end
				if (ext_ram_en !== want.ram_en) begin
					$error("ext_ram_en: expected %0b, got %0b", want.ram_en, ext_ram_en);
					errors++;
				end
				if (current_rom_bank !== want.rom_page) begin
					$error("current_rom_bank: expected 0x%0h, got 0x%0h",
						want.rom_page, current_rom_bank);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fixed_map();
		test_bank_controller();
		test_random_traffic(600);
		set_banking(1'b0);
		test_random_traffic(250);
		set_banking(1'b1);
		test_back_to_back(300);
		test_random_traffic(400);
		drain_pipeline();
		if (pending_q.size() != 0) begin
			$error("%0d results never arrived", pending_q.size());
			errors++;
		end
		$display("Checked %0d result beats, %0d of the accesses reprogrammed the bank controller.",
			checked, bank_updates);
		$display("Region counts 0..10: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
			region_hits[0], region_hits[1], region_hits[2], region_hits[3], region_hits[4],
			region_hits[5], region_hits[6], region_hits[7], region_hits[8], region_hits[9],
			region_hits[10]);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
design/bmmd_pkg.sv
design/banked_memory_map_decoder.sv
bench/tb.sv
